[design/scos_pkg.sv]
package scos_pkg;

  localparam int ENDPOINT_SCALE = 100;
  localparam int SUBTRIM_STEP   = 2;
  localparam int TRAVEL_LIMIT   = 640;
  localparam int SLOW_MAX       = 100;
  localparam int STICK_SPAN     = 512;
  localparam int WINDOW_MS      = 15;
  localparam int SERVO_MAX      = 4095;

  // |mix| * endpoint, then divide by ENDPOINT_SCALE via reciprocal (exact for PROD_W bits)
  localparam int MAG_W     = 12;
  localparam int PROD_W    = 20;
  localparam int DIV_SHIFT = PROD_W + $clog2(ENDPOINT_SCALE);
  localparam int RECIP_W   = PROD_W + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'(1) << DIV_SHIFT) + 64'(ENDPOINT_SCALE) - 64'(1)) / 64'(ENDPOINT_SCALE));
  localparam int TGT_W     = PROD_W + 2;
  localparam int MAP_W     = 23;
  localparam int SV_W      = 16;

  localparam logic CFG_CENTER = 1'b0;
  localparam logic CFG_SPAN   = 1'b1;

  typedef logic signed [10:0] value_t;

  typedef struct packed {
    logic latch;
    logic tick;
    logic update;
    logic push;
  } scos_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic ch_bad;
    logic out_free;
  } scos_sts_t;

endpackage

[design/scos_ctrl.sv]
module scos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  scos_pkg::scos_sts_t sts_i,
  output scos_pkg::scos_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_MAP  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd_o        = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.latch = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        // ticks finish here; value requests on a missing channel are dropped
        if (sts_i.is_tick) begin
          cmd_o.tick = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts_i.ch_bad) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: state_nxt = ST_UPD;
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_nxt    = ST_MAP;
      end
      ST_MAP: state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.push |-> sts_i.out_free)
    else $error("result pushed into a full output register");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_MUL))
    else $error("accepted request did not start processing");

  a_update_then_map: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.update |=> (state_r == ST_MAP) ##1 (state_r == ST_OUT))
    else $error("store update not followed by mapping");

endmodule

[design/scos_dp.sv]
module scos_dp #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [79:0]         in_tdata,
  input  logic                in_tuser,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_addr,
  input  logic [11:0]         cfg_wdata,
  input  scos_pkg::scos_cmd_t cmd_i,
  output scos_pkg::scos_sts_t sts_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // latched request
  logic        tick_r;
  logic [31:0] now_r;
  logic [2:0]  ch_r;
  logic signed [11:0] mix_r;
  logic [7:0]  epn_r, epp_r;
  logic        rev_r;
  logic signed [7:0] sub_r;
  logic [7:0]  slow_r;

  logic [11:0] center_r;
  logic [10:0] span_r;
  logic        active_r;
  logic [31:0] next_win_r;
  scos_pkg::value_t store_r [CHANNELS];

  logic [scos_pkg::PROD_W-1:0] prod_r;
  logic [scos_pkg::PROD_W-1:0] quo_r;
  scos_pkg::value_t            new_r;
  logic signed [scos_pkg::MAP_W-1:0] map_r;

  logic        out_valid_r;
  logic [2:0]  out_ch_r;
  logic [10:0] out_val_r;
  logic [11:0] out_servo_r;

  logic [IDX_W-1:0] idx;
  logic [scos_pkg::MAG_W-1:0] mag;
  logic [7:0] ep;
  logic [scos_pkg::PROD_W+scos_pkg::RECIP_W-1:0] recip_prod;

  logic signed [scos_pkg::TGT_W-1:0] scaled, trim, tgt_sum;
  scos_pkg::value_t tgt, cur, stepped, new_val;
  logic        slow_en;
  logic [7:0]  ds;
  logic signed [11:0] dv;
  logic [11:0] dv_abs;

  logic signed [31:0] delta;
  logic signed [scos_pkg::SV_W-1:0] sv_sum;
  logic [11:0] servo;

  assign idx        = IDX_W'(ch_r);
  assign mag        = mix_r[11] ? scos_pkg::MAG_W'(-mix_r) : scos_pkg::MAG_W'(mix_r);
  assign ep         = mix_r[11] ? epn_r : epp_r;
  assign recip_prod = scos_pkg::PROD_W'(prod_r) * scos_pkg::DIV_RECIP;

  assign sts_o.is_tick  = tick_r;
  assign sts_o.ch_bad   = (5'(ch_r) >= 5'(CHANNELS));
  assign sts_o.out_free = !out_valid_r || out_tready;

  // target: sign, reverse, subtrim, clamp
  always_comb begin
    scaled = $signed({2'b00, quo_r});
    if (mix_r[11] ^ rev_r) begin
      scaled = -scaled;
    end
    trim    = scos_pkg::TGT_W'(sub_r) * scos_pkg::TGT_W'(scos_pkg::SUBTRIM_STEP);
    tgt_sum = scaled + trim;
    if (tgt_sum > scos_pkg::TGT_W'(scos_pkg::TRAVEL_LIMIT)) begin
      tgt = 11'(scos_pkg::TRAVEL_LIMIT);
    end else if (tgt_sum < -scos_pkg::TGT_W'(scos_pkg::TRAVEL_LIMIT)) begin
      tgt = -11'(scos_pkg::TRAVEL_LIMIT);
    end else begin
      tgt = 11'(tgt_sum);
    end
  end

  // slewing toward the target
  always_comb begin
    cur     = store_r[idx];
    slow_en = (slow_r != 8'd0) && (slow_r <= 8'(scos_pkg::SLOW_MAX));
    ds      = 8'(scos_pkg::SLOW_MAX) - slow_r + 8'd1;
    dv      = 12'(tgt) - 12'(cur);
    dv_abs  = dv[11] ? 12'(-dv) : 12'(dv);
    stepped = dv[11] ? 11'(12'(cur) - $signed({4'b0000, ds}))
                     : 11'(12'(cur) + $signed({4'b0000, ds}));
    if (!slow_en) begin
      new_val = tgt;
    end else if (!active_r) begin
      new_val = cur;
    end else if (dv_abs < {4'b0000, ds}) begin
      new_val = tgt;
    end else begin
      new_val = stepped;
    end
  end

  // pulse mapping, truncating toward zero
  always_comb begin
    delta  = 32'(map_r) / scos_pkg::STICK_SPAN;
    sv_sum = $signed({4'b0000, center_r}) + scos_pkg::SV_W'(delta);
    if (sv_sum < 0) begin
      servo = 12'd0;
    end else if (sv_sum > scos_pkg::SV_W'(scos_pkg::SERVO_MAX)) begin
      servo = 12'(scos_pkg::SERVO_MAX);
    end else begin
      servo = 12'(sv_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      tick_r <= in_tuser;
      now_r  <= in_tdata[31:0];
      ch_r   <= in_tdata[34:32];
      mix_r  <= $signed(in_tdata[46:35]);
      epn_r  <= in_tdata[54:47];
      epp_r  <= in_tdata[62:55];
      rev_r  <= in_tdata[63];
      sub_r  <= $signed(in_tdata[71:64]);
      slow_r <= in_tdata[79:72];
    end
    prod_r <= scos_pkg::PROD_W'(mag * ep);
    quo_r  <= scos_pkg::PROD_W'(recip_prod >> scos_pkg::DIV_SHIFT);
    if (cmd_i.update) begin
      new_r <= new_val;
    end
    map_r <= scos_pkg::MAP_W'(new_r) * $signed({1'b0, span_r});
    if (cmd_i.push) begin
      out_ch_r    <= ch_r;
      out_val_r   <= new_r;
      out_servo_r <= servo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= 12'd1500;
      span_r      <= 11'd500;
      active_r    <= 1'b0;
      next_win_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          scos_pkg::CFG_CENTER: center_r <= cfg_wdata;
          scos_pkg::CFG_SPAN:   span_r   <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        if (next_win_r <= now_r) begin
          next_win_r <= now_r + 32'(scos_pkg::WINDOW_MS);
          active_r   <= 1'b1;
        end else begin
          active_r <= 1'b0;
        end
      end
      if (cmd_i.update) begin
        store_r[idx] <= new_val;
      end
      if (cmd_i.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_servo_r, out_val_r, out_ch_r};

  a_shaped_in_travel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.push |-> (int'(new_r) <= scos_pkg::TRAVEL_LIMIT &&
                    int'(new_r) >= -scos_pkg::TRAVEL_LIMIT))
    else $error("shaped value beyond travel limit");

endmodule

[design/servo_channel_output_shaper_unit.sv]
// Servo channel output shaper.
// Input stream (in_*): one request per handshake. in_tuser = 0 is a channel value
// request, which returns one result; in_tuser = 1 is a timing tick carrying the
// millisecond time, which opens or closes the 15 ms slow-update window and
// returns nothing. Value requests for a channel at or above CHANNELS are dropped.
// Output stream (out_*): channel, stored shaped value and servo pulse value.
// Config port: cfg_we writes cfg_wdata to register cfg_addr (0 centre, 1 span)
// in the same cycle; write only while the unit is idle.
// Sequencing: requests are handled one at a time by a six-state sequencer. A value
// request is accepted, then passes the endpoint multiply, reciprocal divide, target
// and slew update, span multiply and output states before its result sits in
// the output register; the output state waits for a free output register, and
// only then is the next request accepted. A tick completes in the multiply state.
// The output register frees the input side: a new request is accepted while a
// result waits; if the receiver stalls, the next result holds in the sequencer.
// Reset (synchronous, rst_n low) clears all channel values to zero, closes the
// slow window, zeroes the window time and restores centre 1500 and span 500.
module servo_channel_output_shaper_unit #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], channel[34:32], mix_value[46:35], endpoint_negative[54:47],
  // endpoint_positive[62:55], reverse[63], subtrim[71:64], slow_setting[79:72]
  input  logic [79:0] in_tdata,
  // req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_channel[2:0], shaped_value[13:3], servo_value[25:14], zero pad
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  scos_pkg::scos_cmd_t cmd;
  scos_pkg::scos_sts_t sts;

  scos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  scos_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
